### rtl/djs_pkg.sv
// djs_pkg: shared types and constants for the deadline job sequencer
// no dependencies
package djs_pkg;
    localparam int MaxJobs = 16;
    localparam int MaxDeadline = 16;
    localparam int ProfitBits = 16;
    localparam int CntW = $clog2(MaxJobs + 1);
    localparam int IdxW = $clog2(MaxJobs);
    localparam int SlotW = $clog2(MaxDeadline);
    localparam int DlW = $clog2(MaxDeadline + 1);
    localparam int TotW = ProfitBits + IdxW + 1;
    localparam logic [19:0] AmountMax = 20'hFFFFF;

    localparam logic [1:0] KIND_JOB = 2'd0;
    localparam logic [1:0] KIND_SLOT = 2'd1;
    localparam logic [1:0] KIND_TOTAL = 2'd2;

    typedef struct packed {
        logic [4:0]  deadline;
        logic [15:0] profit;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  job_index;
        logic [3:0]  slot;
        logic        scheduled;
        logic [19:0] amount;
        logic        overflow;
        logic        end_of_run;
    } out_item_t;

    // one job as it travels down the sorting chain
    typedef struct packed {
        logic                  valid;
        logic [DlW-1:0]        deadline;
        logic [ProfitBits-1:0] profit;
        logic [IdxW-1:0]       index;
    } job_t;
endpackage

### rtl/djs_sort_cell.sv
// djs_sort_cell: one cell of the insertion sorting chain
// depends on djs_pkg
module djs_sort_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          shift,
    input  djs_pkg::job_t in_job,
    input  djs_pkg::job_t prev_job,
    input  logic          prev_shift,
    output djs_pkg::job_t held,
    output logic          take
);
    djs_pkg::job_t held_reg;
    djs_pkg::job_t held_next;

    // a new job displaces this cell when it beats the held job strictly
    assign take = in_job.valid && (!held_reg.valid || (in_job.profit > held_reg.profit));
    assign held = held_reg;

    always_comb
    begin
        held_next = held_reg;
        if (clear)
        begin
            held_next = '0;
        end
        else if (shift)
        begin
            held_next = prev_job;
        end
        else if (take)
        begin
            held_next = prev_shift ? prev_job : in_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end
endmodule

### rtl/djs_sort_chain.sv
// djs_sort_chain: row of sorting cells kept in descending profit order
// depends on djs_pkg, djs_sort_cell
module djs_sort_chain (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          pop,
    input  djs_pkg::job_t in_job,
    output djs_pkg::job_t head
);
    localparam int N = djs_pkg::MaxJobs;
    djs_pkg::job_t held [N];
    djs_pkg::job_t prev [N];
    logic          take [N];
    logic          pshift [N];

    // insertion: cells that take form a suffix; each takes its predecessor
    // if that one also takes, else the new job
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (pop)
            begin
                prev[i] = (i == N - 1) ? '0 : held[(i + 1) % N];
                pshift[i] = 1'b0;
            end
            else
            begin
                prev[i] = (i == 0) ? '0 : held[(i + N - 1) % N];
                pshift[i] = (i == 0) ? 1'b0 : take[(i + N - 1) % N];
            end
        end
    end

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        djs_sort_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (clear),
            .shift     (pop),
            .in_job    (pop ? '0 : in_job),
            .prev_job  (prev[g]),
            .prev_shift(pshift[g]),
            .held      (held[g]),
            .take      (take[g])
        );
    end

    assign head = held[0];
endmodule

### rtl/djs_slot_row.sv
// djs_slot_row: slot occupancy and owners with latest-free search
// depends on djs_pkg
module djs_slot_row (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        place,
    input  logic [djs_pkg::DlW-1:0]     deadline,
    input  logic [djs_pkg::IdxW-1:0]    job,
    input  logic [djs_pkg::SlotW-1:0]   rd_slot,
    output logic                        found,
    output logic [djs_pkg::SlotW-1:0]   found_slot,
    output logic                        rd_valid,
    output logic [djs_pkg::IdxW-1:0]    rd_owner
);
    localparam int N = djs_pkg::MaxDeadline;
    logic [N-1:0]                    valid_reg;
    logic [djs_pkg::IdxW-1:0]        owner_reg [N];

    always_comb
    begin
        found = 1'b0;
        found_slot = '0;
        for (int s = 0; s < N; s++)
        begin
            if (!valid_reg[s] && (s < int'(deadline)))
            begin
                found = 1'b1;
                found_slot = djs_pkg::SlotW'(s);
            end
        end
    end

    assign rd_valid = valid_reg[rd_slot];
    assign rd_owner = owner_reg[rd_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (place && found)
        begin
            valid_reg[found_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (place && found)
        begin
            owner_reg[found_slot] <= job;
        end
    end
endmodule

### rtl/deadline_job_sequencer_unit.sv
// deadline_job_sequencer_unit: top level of the greedy job sequencer
// depends on djs_pkg, djs_sort_chain, djs_slot_row
// Jobs load one per cycle and are inserted into a chain of sorting cells as
// they arrive, so the list is in descending profit order (ties by arrival)
// when the last job lands. After that the block emits one decision per job
// at one result per cycle while the output does not stall, then one record
// per slot up to the largest deadline, then the total; input stalls during
// this phase. With n jobs and largest deadline m it gives n decisions, a
// turnaround step with no result, m slot records and the total, each
// stretched by any output stall.
module deadline_job_sequencer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  djs_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output djs_pkg::out_item_t  out_data
);
    typedef enum logic [1:0] {LOAD, JOBS, SLOTS, TOTAL} state_t;

    state_t                         state_reg;
    logic [djs_pkg::CntW-1:0]       count_reg;
    logic [djs_pkg::DlW-1:0]        maxd_reg;
    logic [djs_pkg::SlotW:0]        slot_reg;
    logic [djs_pkg::TotW-1:0]       total_reg;
    logic                           ovf_reg;
    logic                           out_valid_reg;
    djs_pkg::out_item_t             out_reg;

    djs_pkg::job_t                  in_job;
    djs_pkg::job_t                  head;
    logic                           found;
    logic [djs_pkg::SlotW-1:0]      found_slot;
    logic                           rd_valid;
    logic [djs_pkg::IdxW-1:0]       rd_owner;
    logic                           out_free;
    logic                           accept;
    logic                           pop;
    logic                           clear;
    logic                           issue;
    logic [djs_pkg::DlW-1:0]        dl_sat;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != LOAD);
    assign accept = in_valid && !in_stall;
    assign pop = (state_reg == JOBS) && out_free && head.valid;
    assign clear = (state_reg == TOTAL) && out_free;
    assign issue = out_free && (((state_reg == JOBS) && head.valid) ||
                                (state_reg == SLOTS) || (state_reg == TOTAL));

    always_comb
    begin
        if (in_data.deadline > 5'(djs_pkg::MaxDeadline))
        begin
            dl_sat = djs_pkg::DlW'(djs_pkg::MaxDeadline);
        end
        else
        begin
            dl_sat = djs_pkg::DlW'(in_data.deadline);
        end
        in_job.valid = accept && (count_reg < djs_pkg::CntW'(djs_pkg::MaxJobs));
        in_job.deadline = dl_sat;
        in_job.profit = djs_pkg::ProfitBits'(in_data.profit);
        in_job.index = djs_pkg::IdxW'(count_reg);
    end

    djs_sort_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .pop   (pop),
        .in_job(in_job),
        .head  (head)
    );

    djs_slot_row u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .place     (pop),
        .deadline  (head.deadline),
        .job       (head.index),
        .rd_slot   (slot_reg[djs_pkg::SlotW-1:0]),
        .found     (found),
        .found_slot(found_slot),
        .rd_valid  (rd_valid),
        .rd_owner  (rd_owner)
    );

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            count_reg <= '0;
            maxd_reg <= '0;
            slot_reg <= '0;
            total_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !issue)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                LOAD:
                begin
                    if (accept)
                    begin
                        if (in_job.valid)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (dl_sat > maxd_reg)
                            begin
                                maxd_reg <= dl_sat;
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (in_data.last)
                        begin
                            state_reg <= JOBS;
                        end
                    end
                end
                JOBS:
                begin
                    if (out_free)
                    begin
                        if (head.valid)
                        begin
                            out_valid_reg <= 1'b1;
                            out_reg.kind <= djs_pkg::KIND_JOB;
                            out_reg.job_index <= 4'(head.index);
                            out_reg.slot <= found ? 4'(found_slot) : 4'd0;
                            out_reg.scheduled <= found;
                            out_reg.amount <= 20'(head.profit);
                            out_reg.overflow <= ovf_reg;
                            out_reg.end_of_run <= 1'b0;
                            if (found)
                            begin
                                total_reg <= total_reg + djs_pkg::TotW'(head.profit);
                            end
                        end
                        else
                        begin
                            slot_reg <= '0;
                            state_reg <= (maxd_reg == '0) ? TOTAL : SLOTS;
                        end
                    end
                end
                SLOTS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.kind <= djs_pkg::KIND_SLOT;
                        out_reg.job_index <= rd_valid ? 4'(rd_owner) : 4'd0;
                        out_reg.slot <= 4'(slot_reg);
                        out_reg.scheduled <= rd_valid;
                        out_reg.amount <= '0;
                        out_reg.overflow <= ovf_reg;
                        out_reg.end_of_run <= 1'b0;
                        slot_reg <= slot_reg + 1'b1;
                        if ((djs_pkg::DlW)'(slot_reg) + 1'b1 == maxd_reg)
                        begin
                            state_reg <= TOTAL;
                        end
                    end
                end
                TOTAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.kind <= djs_pkg::KIND_TOTAL;
                        out_reg.job_index <= '0;
                        out_reg.slot <= '0;
                        out_reg.scheduled <= 1'b0;
                        out_reg.amount <= (total_reg > djs_pkg::TotW'(djs_pkg::AmountMax))
                                          ? djs_pkg::AmountMax : 20'(total_reg);
                        out_reg.overflow <= ovf_reg;
                        out_reg.end_of_run <= 1'b1;
                        count_reg <= '0;
                        maxd_reg <= '0;
                        total_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= LOAD;
                    end
                end
                default:
                begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end
endmodule
